>>> rtl/dock_command_byte_parser_core_assert.svh
// Assertion macros shared by the parser RTL modules.
`ifndef DOCK_COMMAND_BYTE_PARSER_CORE_ASSERT_SVH
`define DOCK_COMMAND_BYTE_PARSER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dcbp_pkg.sv
// Shared types and constants of the dock command byte parser.
`timescale 1ns / 1ps
`default_nettype none
package dcbp_pkg;

  // Width of the payload fill count; covers the largest payload depth.
  localparam int CNT_W = 6;

  // Command codes of the result items.
  localparam logic [3:0] CMD_TEST_TOGGLE = 4'd0;
  localparam logic [3:0] CMD_DOCK_SELECT = 4'd1;
  localparam logic [3:0] CMD_SAVE        = 4'd2;
  localparam logic [3:0] CMD_CLEAR_STORE = 4'd3;
  localparam logic [3:0] CMD_RESTART     = 4'd4;
  localparam logic [3:0] CMD_FFB_TEST    = 4'd5;
  localparam logic [3:0] CMD_BRIGHTNESS  = 4'd6;
  localparam logic [3:0] CMD_CALIBRATE   = 4'd7;
  localparam logic [3:0] CMD_STORE_UPD   = 4'd8;
  localparam logic [3:0] CMD_READ_TOGGLE = 4'd9;
  localparam logic [3:0] CMD_READ_PINS   = 4'd10;
  localparam logic [3:0] CMD_READ_SETUP  = 4'd11;
  localparam logic [3:0] CMD_READ_PROF   = 4'd12;
  localparam logic [3:0] CMD_READ_USB    = 4'd13;

  // Protocol characters.
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UP_C  = 8'h43;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_LO_C  = 8'h63;
  localparam logic [7:0] CH_LO_M  = 8'h6D;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_I  = 8'h69;

  // One operation handed from the parser to the emitter.
  typedef struct packed {
    logic             is_run;
    logic [3:0]       command;
    logic             has_argument;
    logic [7:0]       argument;
    logic [CNT_W-1:0] run_count;
    logic             truncated;
  } dcbp_op_t;

  // One result item as presented on the output ports.
  typedef struct packed {
    logic [3:0] command;
    logic       has_argument;
    logic [7:0] argument;
    logic       last;
    logic       truncated;
  } dcbp_result_t;

  // Payload store write request from the parser.
  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] addr;
    logic [7:0]       data;
  } dcbp_wr_t;

endpackage
`default_nettype wire

>>> rtl/dcbp_parser.sv
// Front end: accepts bytes, runs the command state machine, fills the payload store.
`timescale 1ns / 1ps
`default_nettype none
module dcbp_parser
  import dcbp_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = 63
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  output logic            op_push,
  output dcbp_op_t        op,
  input  wire logic       fifo_full,
  output dcbp_wr_t        wr,
  input  wire logic       run_done
);

  `include "dock_command_byte_parser_core_assert.svh"

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_HEADER    = 4'd1;
  localparam logic [3:0] ST_BRIGHT    = 4'd2;
  localparam logic [3:0] ST_CAL_IDX   = 4'd3;
  localparam logic [3:0] ST_CAL_CONF  = 4'd4;
  localparam logic [3:0] ST_MAP       = 4'd5;
  localparam logic [3:0] ST_MAP_DATA  = 4'd6;
  localparam logic [3:0] ST_READ_SEL  = 4'd7;
  localparam logic [3:0] ST_READ_PROF = 4'd8;
  localparam logic [3:0] ST_REBOOT    = 4'd9;
  localparam logic [3:0] ST_FFB       = 4'd10;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PAYLOAD_DEPTH);

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       cal_idx_r, cal_idx_nxt;
  logic             enabled_r;
  logic             busy_r, busy_nxt;
  logic             accept;
  logic             emit;

  // A byte is taken unless the queue is full or a payload run is still draining.
  assign in_full = fifo_full | busy_r;
  assign accept  = in_push & ~in_full;
  assign op_push = accept & emit & enabled_r;

  // Command state machine.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    cal_idx_nxt = cal_idx_r;
    emit        = 1'b0;
    op          = '0;
    wr          = '0;
    wr.addr     = count_r;
    wr.data     = in_data_byte;
    if (accept) begin
      unique case (state_r) inside
        ST_HEADER: begin
          state_nxt = ST_IDLE;
          unique case (in_data_byte)
            CH_UP_B: state_nxt = ST_BRIGHT;
            CH_UP_T: begin
              emit = 1'b1;
              op.command = CMD_TEST_TOGGLE;
            end
            CH_UP_P: begin
              emit = 1'b1;
              op.command = CMD_DOCK_SELECT;
              op.has_argument = 1'b1;
              op.argument = 8'd1;
            end
            CH_UP_E: begin
              emit = 1'b1;
              op.command = CMD_DOCK_SELECT;
              op.has_argument = 1'b1;
            end
            CH_UP_C: state_nxt = ST_CAL_IDX;
            CH_UP_S: begin
              emit = 1'b1;
              op.command = CMD_SAVE;
            end
            CH_LO_C: begin
              emit = 1'b1;
              op.command = CMD_CLEAR_STORE;
            end
            CH_LO_M: state_nxt = ST_MAP;
            CH_LO_L: state_nxt = ST_READ_SEL;
            CH_LO_T: state_nxt = ST_FFB;
            CH_LO_X: state_nxt = ST_REBOOT;
            default: state_nxt = ST_HEADER;
          endcase
        end
        ST_REBOOT: begin
          emit = (in_data_byte == CH_LO_X);
          op.command = CMD_RESTART;
          state_nxt = ST_IDLE;
        end
        ST_FFB, ST_BRIGHT, ST_READ_PROF: begin
          emit = 1'b1;
          op.has_argument = 1'b1;
          op.argument = in_data_byte;
          op.command = (state_r == ST_FFB)    ? CMD_FFB_TEST :
                       (state_r == ST_BRIGHT) ? CMD_BRIGHTNESS : CMD_READ_PROF;
          state_nxt = ST_IDLE;
        end
        ST_CAL_IDX: begin
          cal_idx_nxt = in_data_byte;
          state_nxt = ST_CAL_CONF;
        end
        ST_CAL_CONF: begin
          emit = (in_data_byte == CH_UP_C);
          op.command = CMD_CALIBRATE;
          op.has_argument = 1'b1;
          op.argument = cal_idx_r;
          state_nxt = ST_IDLE;
        end
        ST_MAP: begin
          if (in_data_byte == CH_DOT) begin
            count_nxt = '0;
            ovf_nxt = 1'b0;
            state_nxt = ST_MAP_DATA;
          end else if (in_data_byte == CH_UP_X) begin
            state_nxt = ST_HEADER;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        ST_MAP_DATA: begin
          if (in_data_byte == CH_UP_X || in_data_byte == CH_DOT) begin
            // Close the run; the emitter walks the store.
            emit = 1'b1;
            op.is_run = 1'b1;
            op.command = CMD_STORE_UPD;
            op.run_count = count_r;
            op.truncated = ovf_r;
            state_nxt = (in_data_byte == CH_UP_X) ? ST_HEADER : ST_IDLE;
          end else if (count_r < DEPTH_CNT) begin
            wr.en = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        ST_READ_SEL: begin
          state_nxt = ST_IDLE;
          unique case (in_data_byte)
            CH_LO_B: begin
              emit = 1'b1;
              op.command = CMD_READ_TOGGLE;
            end
            CH_LO_P: begin
              emit = 1'b1;
              op.command = CMD_READ_PINS;
            end
            CH_LO_S: begin
              emit = 1'b1;
              op.command = CMD_READ_SETUP;
            end
            CH_UP_P: state_nxt = ST_READ_PROF;
            CH_LO_I: begin
              emit = 1'b1;
              op.command = CMD_READ_USB;
            end
            default: state_nxt = ST_READ_SEL;
          endcase
        end
        default: begin
          // Idle, and any code that means nothing.
          state_nxt = (in_data_byte == CH_UP_X) ? ST_HEADER : ST_IDLE;
        end
      endcase
    end
  end

  // A run stays pending from its transfer into the queue until its last result is loaded.
  always_comb begin
    busy_nxt = busy_r;
    if (op_push && op.is_run) begin
      busy_nxt = 1'b1;
    end else if (run_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      cal_idx_r <= '0;
      enabled_r <= 1'b1;
      busy_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      cal_idx_r <= cal_idx_nxt;
      busy_r    <= busy_nxt;
      if (cfg_wr_en) begin
        enabled_r <= cfg_wr_data;
      end
    end
  end

  `DCBP_ASSERT_NOW(a_push_room, op_push, !fifo_full, "operation pushed into a full queue")
  `DCBP_ASSERT_NOW(a_wr_range, wr.en, wr.addr < DEPTH_CNT, "payload write beyond store depth")
  `DCBP_ASSERT_NOW(a_busy_quiet, busy_r, !op_push && !wr.en, "parser active during a run")

endmodule
`default_nettype wire

>>> rtl/dcbp_cmd_fifo.sv
// Two-entry queue of operations between the parser and the emitter.
`timescale 1ns / 1ps
`default_nettype none
module dcbp_cmd_fifo
  import dcbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  dcbp_op_t      push_op,
  output logic          full,
  input  wire logic     pop,
  output dcbp_op_t      head_op,
  output logic          empty
);

  dcbp_op_t   slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] fill_r;
  logic       do_push, do_pop;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head_op = slot_r[rptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      fill_r <= fill_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_op;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dcbp_emitter.sv
// Back end: holds the payload store and delivers result items, walking the store for a run.
`timescale 1ns / 1ps
`default_nettype none
module dcbp_emitter
  import dcbp_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = 63
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  dcbp_wr_t   wr,
  input  dcbp_op_t   head_op,
  input  wire logic  fifo_empty,
  output logic       fifo_pop,
  output logic       run_done,
  output logic       out_empty,
  input  wire logic  out_pop,
  output dcbp_result_t out_res
);

  `include "dock_command_byte_parser_core_assert.svh"

  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_LOAD = 2'd2;
  localparam logic [1:0] B_TAIL = 2'd3;

  logic [7:0]       mem [PAYLOAD_DEPTH];
  logic [7:0]       rd_data_r;
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             trunc_r, trunc_nxt;
  logic             out_valid_r;
  dcbp_result_t     out_r;
  logic             out_free;
  logic             load;
  dcbp_result_t     load_val;

  assign out_empty = ~out_valid_r;
  assign out_res   = out_r;
  assign out_free  = ~out_valid_r | out_pop;

  // Payload store: one write port from the parser, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
    rd_data_r <= mem[idx_r[ADDR_W-1:0]];
  end

  // Delivery sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    trunc_nxt = trunc_r;
    fifo_pop  = 1'b0;
    run_done  = 1'b0;
    load      = 1'b0;
    load_val  = '0;
    unique case (state_r)
      B_IDLE: begin
        if (!fifo_empty && out_free) begin
          fifo_pop = 1'b1;
          if (head_op.is_run) begin
            cnt_nxt   = head_op.run_count;
            trunc_nxt = head_op.truncated;
            idx_nxt   = '0;
            state_nxt = (head_op.run_count == '0) ? B_TAIL : B_READ;
          end else begin
            load = 1'b1;
            load_val.command      = head_op.command;
            load_val.has_argument = head_op.has_argument;
            load_val.argument     = head_op.argument;
            load_val.last         = 1'b1;
          end
        end
      end
      B_READ: begin
        state_nxt = B_LOAD;
      end
      B_LOAD: begin
        if (out_free) begin
          load = 1'b1;
          load_val.command      = CMD_STORE_UPD;
          load_val.has_argument = 1'b1;
          load_val.argument     = rd_data_r;
          load_val.truncated    = trunc_r;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (idx_nxt == cnt_r) ? B_TAIL : B_READ;
        end
      end
      B_TAIL: begin
        if (out_free) begin
          // Closing zero byte of the run.
          load = 1'b1;
          load_val.command      = CMD_STORE_UPD;
          load_val.has_argument = 1'b1;
          load_val.last         = 1'b1;
          load_val.truncated    = trunc_r;
          run_done  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      trunc_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      trunc_r <= trunc_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register holds no control state.
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= load_val;
    end
  end

  `DCBP_ASSERT_NEXT(a_out_hold, out_valid_r && !out_pop, out_valid_r && $stable(out_r),
    "waiting result was overwritten")
  `DCBP_ASSERT_NOW(a_idx_range, state_r == B_LOAD, idx_r < cnt_r, "run read past its count")
  `DCBP_ASSERT_NOW(a_done_tail, run_done, state_r == B_TAIL && load, "run ended outside tail")

endmodule
`default_nettype wire

>>> rtl/dock_command_byte_parser_core.sv
// Top level of the dock command byte parser.
// Takes one received serial byte per transfer on the in_ queue side and delivers command
// results on the out_ queue side. A byte is normally taken in the cycle it is offered; the
// parser state machine handles it and, when it completes a command, places one operation
// into a two-entry queue, and in_full also rises while that queue holds two operations.
// The emitter drains the queue into a one-entry output register, so a single result
// passes through the queue and the output register before it can be popped, and the
// input keeps moving while a result waits to be popped. A store update run (after "m.")
// is delivered by walking the payload store through its registered read port: once the
// emitter takes the run off the queue it steps through a read state and a load state for
// each stored byte and a tail state for the closing zero byte, and every load also waits
// while the output register is full. in_full stays high from the byte that closes the run
// until its last result is loaded. cfg_wr_data written with cfg_wr_en set enables
// (1, reset value) or silences (0) all command results.
`timescale 1ns / 1ps
`default_nettype none
module dock_command_byte_parser_core
  import dcbp_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = 63
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_data_byte,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [3:0]      out_command,
  output logic            out_has_argument,
  output logic [7:0]      out_argument,
  output logic            out_last,
  output logic            out_truncated,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);

  logic         op_push;
  dcbp_op_t     op;
  dcbp_op_t     head_op;
  logic         fifo_full;
  logic         fifo_empty;
  logic         fifo_pop;
  dcbp_wr_t     wr;
  logic         run_done;
  dcbp_result_t out_res;

  dcbp_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .op_push      (op_push),
    .op           (op),
    .fifo_full    (fifo_full),
    .wr           (wr),
    .run_done     (run_done)
  );

  dcbp_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (op),
    .full    (fifo_full),
    .pop     (fifo_pop),
    .head_op (head_op),
    .empty   (fifo_empty)
  );

  dcbp_emitter #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .head_op    (head_op),
    .fifo_empty (fifo_empty),
    .fifo_pop   (fifo_pop),
    .run_done   (run_done),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_res    (out_res)
  );

  assign out_command      = out_res.command;
  assign out_has_argument = out_res.has_argument;
  assign out_argument     = out_res.argument;
  assign out_last         = out_res.last;
  assign out_truncated    = out_res.truncated;

endmodule
`default_nettype wire

>>> tb/sv/dock_command_byte_parser_core_test.sv
// Self-checking testbench for the dock command byte parser core.
`timescale 1ns / 1ps
module dock_command_byte_parser_core_test
  import dcbp_pkg::*;
();

  localparam int PAYLOAD_BYTES = 63;
  // A closing run walks the whole store, so the wait scales with the store depth plus margin.
  localparam int SETTLE_CYCLES = 2 * PAYLOAD_BYTES + 16;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  // Parser states of the predictor.
  typedef enum logic [3:0] {
    PS_IDLE, PS_HEADER, PS_BRIGHT, PS_CAL_INDEX, PS_CAL_CONFIRM, PS_MAP,
    PS_MAP_DATA, PS_READ_SEL, PS_READ_PROFILE, PS_REBOOT, PS_FFB
  } parse_state_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [3:0] out_command;
  logic       out_has_argument;
  logic [7:0] out_argument;
  logic       out_last;
  logic       out_truncated;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b1;

  // Predictor state, mirrors the parser after reset.
  parse_state_t parse_state = PS_IDLE;
  logic [7:0]   stored_payload [PAYLOAD_BYTES];
  int           stored_count = 0;
  logic         stored_overflow = 1'b0;
  logic [7:0]   cal_index = 8'h00;
  logic         commands_on = 1'b1;

  dcbp_result_t pending_results [$];
  int           error_count = 0;
  int           bytes_sent = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           quiet_cycles = 0;
  logic [7:0]   read_select_chars [4] = '{CH_LO_B, CH_LO_P, CH_LO_S, CH_LO_I};

  dock_command_byte_parser_core #(
    .PAYLOAD_DEPTH(PAYLOAD_BYTES)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_byte    (in_data_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_command     (out_command),
    .out_has_argument(out_has_argument),
    .out_argument    (out_argument),
    .out_last        (out_last),
    .out_truncated   (out_truncated),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  task automatic expect_result(input logic [3:0] command, input logic has_argument,
                               input logic [7:0] argument, input logic last,
                               input logic truncated);
    dcbp_result_t r;
    r.command = command;
    r.has_argument = has_argument;
    r.argument = argument;
    r.last = last;
    r.truncated = truncated;
    pending_results.push_back(r);
  endtask

  // A one-result command; nothing is produced while commands are off.
  task automatic expect_command(input logic [3:0] command, input logic has_argument,
                                input logic [7:0] argument);
    if (commands_on) begin
      expect_result(command, has_argument, argument, 1'b1, 1'b0);
    end
  endtask

  // Advances the parser prediction by one accepted byte.
  task automatic parse_byte(input logic [7:0] b);
    case (parse_state)
      PS_HEADER: begin
        parse_state = PS_IDLE;
        case (b)
          CH_UP_B: parse_state = PS_BRIGHT;
          CH_UP_T: expect_command(CMD_TEST_TOGGLE, 1'b0, 8'h00);
          CH_UP_P: expect_command(CMD_DOCK_SELECT, 1'b1, 8'h01);
          CH_UP_E: expect_command(CMD_DOCK_SELECT, 1'b1, 8'h00);
          CH_UP_C: parse_state = PS_CAL_INDEX;
          CH_UP_S: expect_command(CMD_SAVE, 1'b0, 8'h00);
          CH_LO_C: expect_command(CMD_CLEAR_STORE, 1'b0, 8'h00);
          CH_LO_M: parse_state = PS_MAP;
          CH_LO_L: parse_state = PS_READ_SEL;
          CH_LO_T: parse_state = PS_FFB;
          CH_LO_X: parse_state = PS_REBOOT;
          default: parse_state = PS_HEADER;
        endcase
      end
      PS_REBOOT: begin
        if (b == CH_LO_X) expect_command(CMD_RESTART, 1'b0, 8'h00);
        parse_state = PS_IDLE;
      end
      PS_FFB: begin
        expect_command(CMD_FFB_TEST, 1'b1, b);
        parse_state = PS_IDLE;
      end
      PS_BRIGHT: begin
        expect_command(CMD_BRIGHTNESS, 1'b1, b);
        parse_state = PS_IDLE;
      end
      PS_CAL_INDEX: begin
        cal_index = b;
        parse_state = PS_CAL_CONFIRM;
      end
      PS_CAL_CONFIRM: begin
        if (b == CH_UP_C) expect_command(CMD_CALIBRATE, 1'b1, cal_index);
        parse_state = PS_IDLE;
      end
      PS_MAP: begin
        if (b == CH_DOT) begin
          stored_count = 0;
          stored_overflow = 1'b0;
          parse_state = PS_MAP_DATA;
        end else begin
          parse_state = (b == CH_UP_X) ? PS_HEADER : PS_IDLE;
        end
      end
      PS_MAP_DATA: begin
        // A closing byte flushes the stored payload as one run.
        if (b == CH_UP_X || b == CH_DOT) begin
          if (commands_on) begin
            for (int i = 0; i < stored_count; i++) begin
              expect_result(CMD_STORE_UPD, 1'b1, stored_payload[i], 1'b0, stored_overflow);
            end
            expect_result(CMD_STORE_UPD, 1'b1, 8'h00, 1'b1, stored_overflow);
          end
          parse_state = (b == CH_UP_X) ? PS_HEADER : PS_IDLE;
        end else if (stored_count < PAYLOAD_BYTES) begin
          stored_payload[stored_count] = b;
          stored_count++;
        end else begin
          stored_overflow = 1'b1;
        end
      end
      PS_READ_SEL: begin
        parse_state = PS_IDLE;
        case (b)
          CH_LO_B: expect_command(CMD_READ_TOGGLE, 1'b0, 8'h00);
          CH_LO_P: expect_command(CMD_READ_PINS, 1'b0, 8'h00);
          CH_LO_S: expect_command(CMD_READ_SETUP, 1'b0, 8'h00);
          CH_UP_P: parse_state = PS_READ_PROFILE;
          CH_LO_I: expect_command(CMD_READ_USB, 1'b0, 8'h00);
          default: parse_state = PS_READ_SEL;
        endcase
      end
      PS_READ_PROFILE: begin
        expect_command(CMD_READ_PROF, 1'b1, b);
        parse_state = PS_IDLE;
      end
      default: parse_state = (b == CH_UP_X) ? PS_HEADER : PS_IDLE;
    endcase
  endtask

  // Sends one byte after a random gap and predicts it once the transfer happens.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_full);
    bytes_sent++;
    parse_byte(b);
  endtask

  // Stops sending and waits until every expected result has been popped.
  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_commands_enabled(input logic value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    commands_on = value;
  endtask

  function automatic logic [7:0] random_payload_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_UP_X || b == CH_DOT) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_store_run(input int length, input logic [7:0] closer);
    send_byte(CH_UP_X);
    send_byte(CH_LO_M);
    send_byte(CH_DOT);
    for (int i = 0; i < length; i++) send_byte(random_payload_byte());
    send_byte(closer);
  endtask

  // Every command but the store update once, with extreme argument values.
  task automatic test_single_commands();
    send_byte(CH_UP_X); send_byte(CH_UP_T);
    send_byte(CH_UP_X); send_byte(CH_UP_P);
    send_byte(CH_UP_X); send_byte(CH_UP_E);
    send_byte(CH_UP_X); send_byte(CH_UP_S);
    send_byte(CH_UP_X); send_byte(CH_LO_C);
    send_byte(CH_UP_X); send_byte(CH_LO_X); send_byte(CH_LO_X);
    send_byte(CH_UP_X); send_byte(CH_LO_T); send_byte(8'h00);
    send_byte(CH_UP_X); send_byte(CH_UP_B); send_byte(8'hFF);
    send_byte(CH_UP_X); send_byte(CH_UP_C); send_byte(8'h80); send_byte(CH_UP_C);
    foreach (read_select_chars[i]) begin
      send_byte(CH_UP_X); send_byte(CH_LO_L); send_byte(read_select_chars[i]);
    end
    send_byte(CH_UP_X); send_byte(CH_LO_L); send_byte(CH_UP_P); send_byte(8'h7F);
  endtask

  // Waiting states, unconfirmed commands and the ways a store update can close.
  task automatic test_special_cases();
    send_byte(CH_UP_X); send_byte(8'h00); send_byte(CH_UP_T);
    send_byte(CH_UP_X); send_byte(CH_LO_L); send_byte(8'hFF); send_byte(CH_LO_B);
    send_byte(CH_UP_X); send_byte(CH_LO_X); send_byte(8'h79);
    send_byte(CH_UP_X); send_byte(CH_UP_C); send_byte(8'h03); send_byte(8'h44);
    send_byte(CH_UP_X); send_byte(CH_LO_M); send_byte(CH_UP_X); send_byte(CH_UP_S);
    send_byte(CH_UP_X); send_byte(CH_LO_M); send_byte(8'h71);
    send_store_run(0, CH_DOT);
    send_store_run(3, CH_UP_X);
    send_byte(CH_UP_E);
  endtask

  // A store that fills and then drops bytes, then a short run to clear the flag.
  task automatic test_payload_overflow();
    send_store_run(PAYLOAD_BYTES + 2, CH_DOT);
    send_store_run(2, CH_DOT);
  endtask

  // With commands off the parser keeps tracking but delivers nothing.
  task automatic test_commands_disabled();
    write_commands_enabled(1'b0);
    send_byte(CH_UP_X); send_byte(CH_UP_T);
    send_byte(CH_UP_X); send_byte(CH_UP_B); send_byte(8'h05);
    send_byte(CH_UP_X); send_byte(CH_UP_C); send_byte(8'h11);
    send_store_run(4, CH_UP_X);
    send_byte(CH_UP_C);
    write_commands_enabled(1'b1);
    send_byte(CH_UP_C);
    send_byte(CH_UP_X); send_byte(CH_LO_L); send_byte(CH_UP_P); send_byte(8'h09);
  endtask

  // One random sequence: mostly well formed, some broken, some noise.
  task automatic send_random_command();
    int pick;
    int length;
    pick = $urandom_range(0, 19);
    if (pick < 14) send_byte(CH_UP_X);
    case (pick)
      0: send_byte(CH_UP_T);
      1: send_byte($urandom_range(0, 1) ? CH_UP_P : CH_UP_E);
      2: send_byte(CH_UP_S);
      3: send_byte(CH_LO_C);
      4: begin
        send_byte(CH_LO_X);
        send_byte($urandom_range(0, 3) != 0 ? CH_LO_X : 8'($urandom_range(0, 255)));
      end
      5: begin send_byte(CH_LO_T); send_byte(8'($urandom_range(0, 255))); end
      6: begin send_byte(CH_UP_B); send_byte(8'($urandom_range(0, 255))); end
      7: begin
        send_byte(CH_UP_C);
        send_byte(8'($urandom_range(0, 255)));
        send_byte($urandom_range(0, 3) != 0 ? CH_UP_C : 8'($urandom_range(0, 255)));
      end
      8: begin
        send_byte(CH_LO_L);
        send_byte(read_select_chars[$urandom_range(0, 3)]);
      end
      9: begin
        send_byte(CH_LO_L); send_byte(CH_UP_P); send_byte(8'($urandom_range(0, 255)));
      end
      10, 11, 12: begin
        // Short payloads; the overflow test covers the long ones.
        length = $urandom_range(0, 8);
        send_byte(CH_LO_M);
        send_byte(CH_DOT);
        for (int i = 0; i < length; i++) send_byte(random_payload_byte());
        send_byte($urandom_range(0, 1) ? CH_DOT : CH_UP_X);
      end
      13: begin send_byte(CH_LO_M); send_byte(8'($urandom_range(0, 255))); end
      14, 15: send_byte(8'($urandom_range(0, 255)));
      16: begin
        send_byte(CH_UP_X); send_byte(8'($urandom_range(0, 255)));
      end
      17: begin
        send_byte(CH_UP_X); send_byte(CH_LO_L); send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        length = $urandom_range(1, 3);
        for (int i = 0; i < length; i++) send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic test_random_traffic(input int byte_budget);
    int start_count;
    start_count = bytes_sent;
    while (bytes_sent - start_count < byte_budget) send_random_command();
    drain_results();
  endtask

  // Random traffic with a silenced stretch in the middle.
  task automatic test_random_with_silence(input int byte_budget);
    test_random_traffic(byte_budget / 3);
    write_commands_enabled(1'b0);
    test_random_traffic(byte_budget / 3);
    write_commands_enabled(1'b1);
    test_random_traffic(byte_budget / 3);
  endtask

  // Result checker and random pop pacing.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result command %0d argument %0h",
                                  out_command, out_argument));
      end else begin
        dcbp_result_t want;
        want = pending_results.pop_front();
        if (out_command !== want.command)
          report_mismatch($sformatf("command %0d, expected %0d", out_command, want.command));
        if (out_has_argument !== want.has_argument)
          report_mismatch($sformatf("has_argument %0b, expected %0b", out_has_argument,
                                    want.has_argument));
        if (out_argument !== want.argument)
          report_mismatch($sformatf("argument %0h, expected %0h", out_argument,
                                    want.argument));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
        if (out_truncated !== want.truncated)
          report_mismatch($sformatf("truncated %0b, expected %0b", out_truncated,
                                    want.truncated));
      end
    end
    out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("dock_command_byte_parser_core_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 36;
    recv_idle_pct = 75;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_commands();
    test_special_cases();
    test_payload_overflow();
    test_commands_disabled();
    test_random_traffic(10);
    send_idle_pct = 75;
    recv_idle_pct = 36;
    test_random_with_silence(24);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(12);
    drain_results();
    if (error_count == 0) begin
      $display("dock_command_byte_parser_core_test OK");
    end else begin
      $display("dock_command_byte_parser_core_test NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/dcbp_pkg.sv
rtl/dcbp_parser.sv
rtl/dcbp_cmd_fifo.sv
rtl/dcbp_emitter.sv
rtl/dock_command_byte_parser_core.sv
tb/sv/dock_command_byte_parser_core_test.sv
